// ===== sv/lrft_pkg.sv =====
// Shared types and constants for the laser range frame tracker.
// Used by lrft_parser and laser_range_frame_tracker_top; no dependencies.
package lrft_pkg;

	localparam int unsigned DistW = 23;
	localparam int unsigned AgeW  = 8;

	localparam logic [7:0] SYNC_FIRST  = 8'h55;
	localparam logic [7:0] SYNC_SECOND = 8'hAA;
	localparam logic [7:0] RSVD_MARK   = 8'hFF;
	localparam logic [7:0] STATUS_GOOD = 8'h01;
	localparam logic [7:0] DATA_BAD    = 8'hFF;
	localparam logic [AgeW-1:0] AGE_MAX = 8'd255;
	localparam logic [6:0] DM_TO_MM    = 7'd100;

	localparam logic [DistW-1:0] RST_BLIND_MM = 23'd500;
	localparam logic [DistW-1:0] RST_MIN_MM   = 23'd500;
	localparam logic [DistW-1:0] RST_MAX_MM   = 23'd1500000;
	localparam logic [AgeW-1:0]  RST_STALE    = 8'd30;

	typedef enum logic [1:0] {
		CFG_STALE_LIMIT = 2'd0,
		CFG_BLIND_ZONE  = 2'd1,
		CFG_MIN_VALID   = 2'd2,
		CFG_MAX_VALID   = 2'd3
	} cfg_index_t;

	typedef enum logic [2:0] {
		PH_SYNC1  = 3'd0,
		PH_SYNC2  = 3'd1,
		PH_CMD    = 3'd2,
		PH_STATUS = 3'd3,
		PH_RSVD   = 3'd4,
		PH_HIGH   = 3'd5,
		PH_LOW    = 3'd6,
		PH_SUM    = 3'd7
	} phase_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] byte_value;
	} in_t;

	typedef struct packed {
		logic [DistW-1:0] range_mm;
		logic             reading_ok;
		logic             in_blind_zone;
		logic             is_stale;
		logic             use_fallback;
		logic             new_frame;
		logic             outside_limits;
		logic [AgeW-1:0]  tick_age;
	} out_t;

	// parser verdict for the byte being fed
	typedef struct packed {
		logic             good;
		logic [DistW-1:0] dist_mm;
	} frame_t;

endpackage

// ===== sv/lrft_parser.sv =====
// Frame parser: sync hunt, byte capture, additive checksum and frame checks.
// Depends on lrft_pkg.
module lrft_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          feed,
	input  logic [7:0]                    byte_value,
	output lrft_pkg::frame_t              frame
);

	lrft_pkg::phase_t phase_q, phase_d;
	logic [7:0] status_q, reserved_q, high_q, low_q, sum_q;
	logic [7:0] sum_add;
	logic [15:0] data_dm;
	logic [22:0] dist_prod;

	assign sum_add   = sum_q + byte_value;
	assign data_dm   = {high_q, low_q};
	assign dist_prod = 23'(data_dm) * 23'(lrft_pkg::DM_TO_MM);

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			lrft_pkg::PH_SYNC1: begin
				if (byte_value == lrft_pkg::SYNC_FIRST) phase_d = lrft_pkg::PH_SYNC2;
			end
			// a wrong second byte restarts the hunt without counting as a first sync
			lrft_pkg::PH_SYNC2: begin
				phase_d = (byte_value == lrft_pkg::SYNC_SECOND) ? lrft_pkg::PH_CMD
				                                                : lrft_pkg::PH_SYNC1;
			end
			lrft_pkg::PH_CMD:    phase_d = lrft_pkg::PH_STATUS;
			lrft_pkg::PH_STATUS: phase_d = lrft_pkg::PH_RSVD;
			lrft_pkg::PH_RSVD:   phase_d = lrft_pkg::PH_HIGH;
			lrft_pkg::PH_HIGH:   phase_d = lrft_pkg::PH_LOW;
			lrft_pkg::PH_LOW:    phase_d = lrft_pkg::PH_SUM;
			lrft_pkg::PH_SUM:    phase_d = lrft_pkg::PH_SYNC1;
			default:             phase_d = lrft_pkg::PH_SYNC1;
		endcase
	end

	always_comb begin
		frame.good    = 1'b0;
		frame.dist_mm = '0;
		unique case (phase_q)
			lrft_pkg::PH_SUM: begin
				if (byte_value == sum_q && status_q == lrft_pkg::STATUS_GOOD &&
				    reserved_q == lrft_pkg::RSVD_MARK &&
				    !(high_q == lrft_pkg::DATA_BAD && low_q == lrft_pkg::DATA_BAD)) begin
					frame.good    = 1'b1;
					frame.dist_mm = dist_prod;
				end
			end
			default: begin
				frame.good    = 1'b0;
				frame.dist_mm = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lrft_pkg::PH_SYNC1;
		end else if (feed) begin
			phase_q <= phase_d;
		end
	end

	// captured bytes are always rewritten before the checksum byte reads them
	always_ff @(posedge clk) begin
		if (feed) begin
			unique case (phase_q)
				lrft_pkg::PH_SYNC2:  sum_q <= lrft_pkg::SYNC_FIRST + lrft_pkg::SYNC_SECOND;
				lrft_pkg::PH_CMD:    sum_q <= sum_add;
				lrft_pkg::PH_STATUS: begin
					status_q <= byte_value;
					sum_q    <= sum_add;
				end
				lrft_pkg::PH_RSVD: begin
					reserved_q <= byte_value;
					sum_q      <= sum_add;
				end
				lrft_pkg::PH_HIGH: begin
					high_q <= byte_value;
					sum_q  <= sum_add;
				end
				lrft_pkg::PH_LOW: begin
					low_q <= byte_value;
					sum_q <= sum_add;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== sv/laser_range_frame_tracker_top.sv =====
// Laser range frame tracker: parses rangefinder frames and flags the kept reading.
// An accepted item's result is in the output register in the cycle after it is accepted.
// Throughput: one item per cycle; the input stalls only while the output register
// holds an untaken result that is not being taken in the same cycle.
// Reset: parser hunts first sync, distance 0, age 255, registers at their defaults.
// Depends on lrft_pkg and lrft_parser.
module laser_range_frame_tracker_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  lrft_pkg::in_t                    in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output lrft_pkg::out_t                   out_data,
	input  logic                             cfg_we,
	input  lrft_pkg::cfg_index_t             cfg_index,
	input  logic [lrft_pkg::DistW-1:0]       cfg_data
);

	logic accept;
	lrft_pkg::frame_t frame;

	logic [lrft_pkg::AgeW-1:0]  stale_q, age_q, age_d;
	logic [lrft_pkg::DistW-1:0] blind_q, min_q, max_q, dist_q, dist_d;
	logic blind, stale, oor, usable;

	logic out_valid_q;
	lrft_pkg::out_t out_q;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	lrft_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.feed       (accept && in_data.action[0]),
		.byte_value (in_data.byte_value),
		.frame      (frame)
	);

	always_comb begin
		dist_d = dist_q;
		age_d  = age_q;
		if (in_data.action[0] && frame.good) begin
			dist_d = frame.dist_mm;
			age_d  = '0;
		end else if (in_data.action[1] && age_q != lrft_pkg::AGE_MAX) begin
			age_d = age_q + 1'b1;
		end
	end

	assign blind  = dist_d < blind_q;
	assign stale  = age_d > stale_q;
	assign oor    = (dist_d < min_q) || (dist_d > max_q);
	assign usable = (dist_d != '0) && !stale && !blind && !oor;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stale_q <= lrft_pkg::RST_STALE;
			blind_q <= lrft_pkg::RST_BLIND_MM;
			min_q   <= lrft_pkg::RST_MIN_MM;
			max_q   <= lrft_pkg::RST_MAX_MM;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lrft_pkg::CFG_STALE_LIMIT: stale_q <= cfg_data[lrft_pkg::AgeW-1:0];
				lrft_pkg::CFG_BLIND_ZONE:  blind_q <= cfg_data;
				lrft_pkg::CFG_MIN_VALID:   min_q   <= cfg_data;
				lrft_pkg::CFG_MAX_VALID:   max_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q      <= '0;
			age_q       <= lrft_pkg::AGE_MAX;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				dist_q <= dist_d;
				age_q  <= age_d;
			end
			// hold the result while stalled, drop it once taken
			if (accept) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q.range_mm       <= dist_d;
			out_q.reading_ok     <= usable;
			out_q.in_blind_zone  <= blind;
			out_q.is_stale       <= stale;
			out_q.use_fallback   <= !usable;
			out_q.new_frame      <= in_data.action[0] && frame.good;
			out_q.outside_limits <= oor;
			out_q.tick_age       <= age_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== sim/range_reading_checker.sv =====
`timescale 1ns / 1ps
// Checker for the laser range frame tracker: tracks the frame parser and kept reading,
// queues one expected reading per accepted input item and compares each result item.
// Depends on lrft_pkg for the port types and protocol constants.
module range_reading_checker import lrft_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  in_t                 in_data,
	input  logic                out_valid,
	input  logic                out_stall,
	input  out_t                out_data,
	input  logic                cfg_we,
	input  cfg_index_t          cfg_index,
	input  logic [DistW-1:0]    cfg_data,
	output int unsigned         mismatches,
	output int unsigned         outstanding
);

	// configuration copy
	logic [AgeW-1:0]  stale_lim;
	logic [DistW-1:0] blind_mm;
	logic [DistW-1:0] min_mm;
	logic [DistW-1:0] max_mm;

	// parser and kept reading
	phase_t           parse_ph;
	logic [7:0]       cap_status;
	logic [7:0]       cap_rsvd;
	logic [7:0]       cap_hi;
	logic [7:0]       cap_lo;
	logic [7:0]       run_sum;
	logic [DistW-1:0] kept_mm;
	logic [AgeW-1:0]  age;

	out_t        expected_readings[$];
	int unsigned errs = 0;

	function automatic void clear_frame();
		parse_ph   = PH_SYNC1;
		cap_status = '0;
		cap_rsvd   = '0;
		cap_hi     = '0;
		cap_lo     = '0;
		run_sum    = '0;
	endfunction

	function automatic out_t track_reading(in_t it);
		out_t        r;
		logic        took;
		logic [7:0]  b;
		logic [31:0] prod;
		logic        blind;
		logic        stale;
		logic        oor;
		logic        usable;
		took = 1'b0;
		prod = '0;
		b    = it.byte_value;
		// action bit 0 carries a byte
		if (it.action[0]) begin
			case (parse_ph)
				PH_SYNC1: begin
					if (b == SYNC_FIRST) parse_ph = PH_SYNC2;
				end
				PH_SYNC2: begin
					if (b == SYNC_SECOND) begin
						parse_ph = PH_CMD;
						run_sum  = SYNC_FIRST + SYNC_SECOND;
					end else begin
						clear_frame();
					end
				end
				PH_CMD: begin
					run_sum  = run_sum + b;
					parse_ph = PH_STATUS;
				end
				PH_STATUS: begin
					cap_status = b;
					run_sum    = run_sum + b;
					parse_ph   = PH_RSVD;
				end
				PH_RSVD: begin
					cap_rsvd = b;
					run_sum  = run_sum + b;
					parse_ph = PH_HIGH;
				end
				PH_HIGH: begin
					cap_hi   = b;
					run_sum  = run_sum + b;
					parse_ph = PH_LOW;
				end
				PH_LOW: begin
					cap_lo   = b;
					run_sum  = run_sum + b;
					parse_ph = PH_SUM;
				end
				default: begin
					if (b == run_sum && cap_status == STATUS_GOOD && cap_rsvd == RSVD_MARK
							&& !(cap_hi == DATA_BAD && cap_lo == DATA_BAD)) begin
						took = 1'b1;
						prod = {cap_hi, cap_lo} * DM_TO_MM;
					end
					clear_frame();
				end
			endcase
		end
		// a completed frame wins over a tick in the same item
		if (took) begin
			kept_mm = prod[DistW-1:0];
			age     = '0;
		end else if (it.action[1] && age != AGE_MAX) begin
			age = age + 1'b1;
		end
		blind  = kept_mm < blind_mm;
		stale  = age > stale_lim;
		oor    = (kept_mm < min_mm) || (kept_mm > max_mm);
		usable = (kept_mm != '0) && !stale && !blind && !oor;
		r.range_mm       = kept_mm;
		r.reading_ok     = usable;
		r.in_blind_zone  = blind;
		r.is_stale       = stale;
		r.use_fallback   = !usable;
		r.new_frame      = took;
		r.outside_limits = oor;
		r.tick_age       = age;
		return r;
	endfunction

	function automatic void check_field(string fname, logic [DistW-1:0] want,
			logic [DistW-1:0] got);
		if (want !== got) begin
			if (errs < 10)
				$display("%0t: %s mismatch, expected %0d got %0d", $time, fname, want, got);
			errs++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			stale_lim = RST_STALE;
			blind_mm  = RST_BLIND_MM;
			min_mm    = RST_MIN_MM;
			max_mm    = RST_MAX_MM;
			clear_frame();
			kept_mm   = '0;
			age       = AGE_MAX;
			expected_readings.delete();
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			// compare the result first: it belongs to an earlier item
			if (out_valid && !out_stall) begin
				if (expected_readings.size() == 0) begin
					if (errs < 10)
						$display("%0t: unexpected reading %p", $time, out_data);
					errs++;
				end else begin
					want = expected_readings.pop_front();
					check_field("range_mm", want.range_mm, out_data.range_mm);
					check_field("reading_ok", want.reading_ok, out_data.reading_ok);
					check_field("in_blind_zone", want.in_blind_zone, out_data.in_blind_zone);
					check_field("is_stale", want.is_stale, out_data.is_stale);
					check_field("use_fallback", want.use_fallback, out_data.use_fallback);
					check_field("new_frame", want.new_frame, out_data.new_frame);
					check_field("outside_limits", want.outside_limits,
						out_data.outside_limits);
					check_field("tick_age", want.tick_age, out_data.tick_age);
				end
			end
			if (in_valid && !in_stall)
				expected_readings.push_back(track_reading(in_data));
			if (cfg_we) begin
				case (cfg_index)
					CFG_STALE_LIMIT: stale_lim = cfg_data[AgeW-1:0];
					CFG_BLIND_ZONE:  blind_mm  = cfg_data;
					CFG_MIN_VALID:   min_mm    = cfg_data;
					default:         max_mm    = cfg_data;
				endcase
			end
			mismatches  <= errs;
			outstanding <= expected_readings.size();
		end
	end

endmodule

// ===== sim/tb_laser_range_frame_tracker_top.sv =====
`timescale 1ns / 1ps
// Testbench top for laser_range_frame_tracker_top: drives rangefinder bytes, ticks and
// limit registers with random idling and stalls. Depends on lrft_pkg and range_reading_checker.
module tb_laser_range_frame_tracker_top import lrft_pkg::*; ();

	localparam logic [1:0] ACT_POLL      = 2'd0;
	localparam logic [1:0] ACT_BYTE      = 2'd1;
	localparam logic [1:0] ACT_TICK      = 2'd2;
	localparam logic [1:0] ACT_BYTE_TICK = 2'd3;
	localparam int         STALL_LIMIT   = 2000;
	localparam int         PHASE_ITEMS   = 215;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	in_t              in_data;
	logic             out_valid;
	logic             out_stall;
	out_t             out_data;
	logic             cfg_we;
	cfg_index_t       cfg_index;
	logic [DistW-1:0] cfg_data;
	int unsigned      mismatches;
	int unsigned      outstanding;

	int items_sent = 0;
	int send_calm  = 0;
	int take_calm  = 0;
	int idle_run   = 0;

	laser_range_frame_tracker_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	range_reading_checker reading_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// idle cycles before an item; now and then a stretch with none
	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 63) == 0) begin
			calm = $urandom_range(16, 64);
			return 0;
		end
		return $urandom_range(0, 15);
	endfunction

	task automatic send_item(input logic [1:0] act, input logic [7:0] b);
		int gap;
		gap = draw_wait(send_calm);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid           <= 1'b1;
		in_data.action     <= act;
		in_data.byte_value <= b;
		items_sent++;
		do @(posedge clk); while (in_stall);
	endtask

	// hold input until every expected reading has come back
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [DistW-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic load_limits(input logic [AgeW-1:0] stale, input logic [DistW-1:0] blind,
			input logic [DistW-1:0] lo_mm, input logic [DistW-1:0] hi_mm);
		write_reg(CFG_STALE_LIMIT, DistW'(stale));
		write_reg(CFG_BLIND_ZONE, blind);
		write_reg(CFG_MIN_VALID, lo_mm);
		write_reg(CFG_MAX_VALID, hi_mm);
	endtask

	// cut < 8 truncates the frame; mixed scatters ticks and polls between bytes
	task automatic send_frame(input logic [7:0] cmd, input logic [7:0] st,
			input logic [7:0] rsv, input logic [7:0] hi, input logic [7:0] lo,
			input logic [7:0] sum_err, input int cut, input bit mixed, input bit bad_sync);
		logic [7:0] frame [8];
		logic [7:0] total;
		logic [1:0] act;
		int         i;
		frame[0] = SYNC_FIRST;
		frame[1] = bad_sync ? 8'($urandom_range(0, 255)) : SYNC_SECOND;
		frame[2] = cmd;
		frame[3] = st;
		frame[4] = rsv;
		frame[5] = hi;
		frame[6] = lo;
		total = '0;
		for (i = 0; i < 7; i++) total = total + frame[i];
		frame[7] = total + sum_err;
		for (i = 0; i < cut; i++) begin
			if (mixed) begin
				if ($urandom_range(0, 7) == 0)
					send_item($urandom_range(0, 1) ? ACT_TICK : ACT_POLL, 8'($urandom));
				act = ($urandom_range(0, 7) == 0) ? ACT_BYTE_TICK : ACT_BYTE;
			end else begin
				act = (i == 7) ? ACT_BYTE_TICK : ACT_BYTE;
			end
			send_item(act, frame[i]);
		end
	endtask

	task automatic random_frame();
		logic [15:0] dm;
		int          flaw;
		case ($urandom_range(0, 9))
			0:       dm = 16'h0000;
			1:       dm = 16'hFFFF;
			2:       dm = 16'hFFFE;
			3:       dm = 16'($urandom_range(0, 10));
			4, 5:    dm = 16'($urandom_range(0, 200));
			6, 7:    dm = 16'($urandom_range(0, 20000));
			default: dm = 16'($urandom);
		endcase
		flaw = $urandom_range(0, 15);
		send_frame(8'($urandom),
			(flaw == 0) ? 8'($urandom) : STATUS_GOOD,
			(flaw == 1) ? 8'($urandom) : RSVD_MARK,
			dm[15:8], dm[7:0],
			(flaw == 2) ? 8'($urandom_range(1, 255)) : 8'h00,
			(flaw == 3) ? $urandom_range(1, 7) : 8,
			1'b1, flaw == 4);
	endtask

	task automatic random_burst();
		case ($urandom_range(0, 15))
			0: repeat ($urandom_range(1, 3)) send_item(2'($urandom), 8'($urandom));
			1: repeat ($urandom_range(1, 40)) send_item(ACT_TICK, 8'($urandom));
			2: send_item(ACT_POLL, 8'($urandom));
			default: random_frame();
		endcase
	endtask

	initial begin : result_taker
		int hold;
		wait (arst_n === 1'b1);
		forever begin
			hold = draw_wait(take_calm);
			if (hold > 0) begin
				@(negedge clk);
				out_stall <= 1'b1;
				repeat (hold - 1) @(negedge clk);
			end
			@(negedge clk);
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin : watchdog
		while (idle_run < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
				idle_run = 0;
			else
				idle_run++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin : stimulus
		int phase;
		int goal;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		out_stall = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = CFG_STALE_LIMIT;
		cfg_data  = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: poll and tick on the empty reading, largest good distance completed
		// together with a tick, wrong second sync byte, then the all-ones data word
		send_item(ACT_POLL, 8'h00);
		send_item(ACT_TICK, 8'hFF);
		send_frame(8'hA5, STATUS_GOOD, RSVD_MARK, 8'hFF, 8'hFE, 8'h00, 8, 1'b0, 1'b0);
		send_item(ACT_BYTE, SYNC_FIRST);
		send_item(ACT_BYTE, SYNC_FIRST);
		send_item(ACT_BYTE, SYNC_SECOND);
		send_frame(8'h5A, STATUS_GOOD, RSVD_MARK, DATA_BAD, DATA_BAD, 8'h00, 8, 1'b0, 1'b0);
		send_item(ACT_TICK, 8'h00);
		send_item(ACT_BYTE_TICK, 8'h00);

		for (phase = 0; phase < 7; phase++) begin
			drain();
			case (phase)
				0: begin
					// age a fresh reading past saturation under the reset limits
					send_frame(8'($urandom), STATUS_GOOD, RSVD_MARK, 8'h00, 8'h64, 8'h00, 8,
						1'b0, 1'b0);
					repeat (270) send_item(ACT_TICK, 8'($urandom));
				end
				1: load_limits(8'd0, '0, '0, 23'h7FFFFF);
				2: load_limits(8'd255, 23'd6553500, 23'd6553500, '0);
				3: load_limits(8'($urandom_range(0, 60)), 23'($urandom_range(0, 20000)),
					23'($urandom_range(0, 100000)), 23'($urandom_range(100000, 6553500)));
				4: load_limits(8'd5, 23'h7FFFFF, '0, 23'd6553500);
				5: load_limits(8'($urandom), 23'($urandom), 23'($urandom), 23'($urandom));
				default: load_limits(RST_STALE, RST_BLIND_MM, RST_MIN_MM, RST_MAX_MM);
			endcase
			goal = items_sent + PHASE_ITEMS;
			while (items_sent < goal) random_burst();
		end

		drain();
		repeat (4) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
